// ----- hdl/slt_pkg.sv -----
// shared types and codes for the sorted list table
package slt_pkg;

   // command codes
   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_RETRIEVE = 2'd2;
   localparam logic [1:0] CMD_SEARCH   = 2'd3;

   // status codes
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_EMPTY    = 3'd1;
   localparam logic [2:0] STS_NOTFOUND = 3'd2;
   localparam logic [2:0] STS_BADPOS   = 3'd3;
   localparam logic [2:0] STS_FULL     = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_WALK,
      ST_FIND,
      ST_REM_SHIFT,
      ST_RET_RD,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/slt_req_if.sv -----
// command channel of the sorted list table
interface slt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] value;
   logic [6:0]         position;

   modport source (output valid, command, value, position, input ready);
   modport sink (input valid, command, value, position, output ready);
endinterface

// ----- hdl/slt_rsp_if.sv -----
// result channel of the sorted list table
interface slt_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] found_value;
   logic [5:0]         found_position;
   logic [6:0]         entry_count;

   modport source (output valid, status, found_value, found_position, entry_count,
                   input ready);
   modport sink (input valid, status, found_value, found_position, entry_count,
                 output ready);
endinterface

// ----- hdl/slt_mem.sv -----
// entry storage: one write port, one read port with registered read data
module slt_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic signed [31:0] rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sorted_list_table.sv -----
// sorted list table top level: sequencer around the entry memory
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+-----------------------------------------------------
//  req_bus  | in  | valid/ready | command, value, position
//  rsp_bus  | out | valid/ready | status, found_value, found_position, entry_count
//
// one command at a time, one entry moved per cycle through one read and one write port
// insert shifts entries up from the top to the first below the value; search and
// remove read up from entry 0, and a remove hit shifts the later entries down
// reset clears the count and sequencer; data read at or above the count is never used
// a result waits in the output register while the next command runs, which then
// holds its result in the done state until that register frees
module sorted_list_table #(
   parameter int DEPTH = 64
) (
   input  logic  clock,
   input  logic  reset,
   slt_req_if.sink   req_bus,
   slt_rsp_if.source rsp_bus
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 7) ? CW : 7;

   slt_pkg::state_type state_ff, state_in;

   logic [1:0]         cmd_ff, cmd_in;
   logic signed [31:0] val_ff, val_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic signed [31:0] res_fval_ff, res_fval_in;
   logic [5:0]         res_fpos_ff, res_fpos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_fval_ff, rsp_fval_in;
   logic [5:0]         rsp_fpos_ff, rsp_fpos_in;
   logic [6:0]         rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] rd_data;

   logic               req_beat;
   logic               rsp_beat;
   logic               out_free;
   logic [CW-1:0]      idx_inc;
   logic [CW-1:0]      idx_dec;
   logic               is_full;
   logic               is_empty;
   logic               pos_bad;
   logic               ins_shift;
   logic               at_end;
   logic               less;
   logic               equal;
   logic               rem_more;

   slt_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshakes
   assign req_bus.ready = (state_ff == slt_pkg::ST_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign rsp_beat      = rsp_valid_ff && rsp_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // shared conditions
   assign idx_inc   = idx_ff + CW'(1);
   assign idx_dec   = idx_ff - CW'(1);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign pos_bad   = (PW'(req_bus.position) >= PW'(count_ff));
   assign less      = (rd_data < val_ff);
   assign equal     = (rd_data == val_ff);
   assign ins_shift = (idx_ff != '0) && !less;
   assign at_end    = (idx_ff == count_ff);
   assign rem_more  = (idx_inc < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slt_pkg::ST_IDLE: begin
            if (req_beat) begin
               case (req_bus.command)
                  slt_pkg::CMD_INSERT: begin
                     state_in = is_full ? slt_pkg::ST_DONE : slt_pkg::ST_INS_WALK;
                  end
                  slt_pkg::CMD_RETRIEVE: begin
                     state_in = (is_empty || pos_bad) ? slt_pkg::ST_DONE
                                                      : slt_pkg::ST_RET_RD;
                  end
                  default: begin
                     state_in = is_empty ? slt_pkg::ST_DONE : slt_pkg::ST_FIND;
                  end
               endcase
            end
         end
         slt_pkg::ST_INS_WALK: begin
            if (!ins_shift) begin
               state_in = slt_pkg::ST_DONE;
            end
         end
         slt_pkg::ST_FIND: begin
            if (at_end || !less) begin
               if (!at_end && equal && (cmd_ff == slt_pkg::CMD_REMOVE)) begin
                  state_in = slt_pkg::ST_REM_SHIFT;
               end else begin
                  state_in = slt_pkg::ST_DONE;
               end
            end
         end
         slt_pkg::ST_REM_SHIFT: begin
            if (!rem_more) begin
               state_in = slt_pkg::ST_DONE;
            end
         end
         slt_pkg::ST_RET_RD: begin
            state_in = slt_pkg::ST_DONE;
         end
         slt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = slt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slt_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   // insert walks down from the top, remove walks up; the write and the
   // read issued in the same cycle during a shift are two entries apart
   always_comb begin
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_fval_in   = res_fval_ff;
      res_fpos_in   = res_fpos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_beat;
      rsp_status_in = rsp_status_ff;
      rsp_fval_in   = rsp_fval_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rd_data;
      rd_addr       = idx_ff[AW-1:0];
      case (state_ff)
         slt_pkg::ST_IDLE: begin
            if (req_beat) begin
               cmd_in        = req_bus.command;
               val_in        = req_bus.value;
               res_status_in = slt_pkg::STS_OK;
               res_fval_in   = '0;
               res_fpos_in   = '0;
               idx_in        = '0;
            end
            case (req_bus.command)
               slt_pkg::CMD_INSERT: begin
                  idx_in  = req_beat ? count_ff : idx_ff;
                  rd_addr = AW'(count_ff - CW'(1));
                  if (req_beat && is_full) begin
                     res_status_in = slt_pkg::STS_FULL;
                  end
               end
               slt_pkg::CMD_RETRIEVE: begin
                  rd_addr = AW'(req_bus.position);
                  if (req_beat && is_empty) begin
                     res_status_in = slt_pkg::STS_EMPTY;
                  end else if (req_beat && pos_bad) begin
                     res_status_in = slt_pkg::STS_BADPOS;
                  end
               end
               default: begin
                  rd_addr = '0;
                  if (req_beat && is_empty) begin
                     res_status_in = slt_pkg::STS_EMPTY;
                  end
               end
            endcase
         end
         slt_pkg::ST_INS_WALK: begin
            wr_en = 1'b1;
            if (ins_shift) begin
               wr_data = rd_data;
               idx_in  = idx_dec;
               rd_addr = AW'(idx_ff - CW'(2));
            end else begin
               wr_data  = val_ff;
               count_in = idx_inc - idx_ff + count_ff;
            end
         end
         slt_pkg::ST_FIND: begin
            if (at_end || (!less && !equal)) begin
               res_status_in = slt_pkg::STS_NOTFOUND;
            end else if (less) begin
               idx_in  = idx_inc;
               rd_addr = AW'(idx_inc);
            end else if (cmd_ff == slt_pkg::CMD_SEARCH) begin
               res_fpos_in = 6'(idx_ff);
            end else begin
               rd_addr = AW'(idx_inc);
            end
         end
         slt_pkg::ST_REM_SHIFT: begin
            if (rem_more) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_inc;
               rd_addr = AW'(idx_ff + CW'(2));
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         slt_pkg::ST_RET_RD: begin
            res_fval_in = rd_data;
         end
         slt_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fval_in   = res_fval_ff;
               rsp_fpos_in   = res_fpos_ff;
               rsp_count_in  = 7'(count_ff);
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_fval_ff   <= res_fval_in;
      res_fpos_ff   <= res_fpos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fval_ff   <= rsp_fval_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // result beat
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.found_value    = rsp_fval_ff;
   assign rsp_bus.found_position = rsp_fpos_ff;
   assign rsp_bus.entry_count    = rsp_count_ff;

`ifndef SYNTH
   // the fill count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond table depth");

   // the memory is written only during a walk
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == slt_pkg::ST_INS_WALK || state_ff == slt_pkg::ST_REM_SHIFT))
      else $error("memory write outside a walk");

   // an accepted command always leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff != slt_pkg::ST_IDLE))
      else $error("command accepted but sequencer stayed idle");

   // the count changes only at the end of an insert or remove walk
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slt_pkg::ST_IDLE || state_ff == slt_pkg::ST_DONE
       || state_ff == slt_pkg::ST_FIND || state_ff == slt_pkg::ST_RET_RD)
      |=> $stable(count_ff))
      else $error("entry count changed outside a walk");

   // a result is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slt_pkg::ST_DONE && rsp_valid_ff && !rsp_bus.ready)
      |=> (state_ff == slt_pkg::ST_DONE))
      else $error("result left done state while output register was busy");
`endif

endmodule
